>>> hdl/cc20_pkg.sv
// Shared types and constants for the ChaCha20 stream cipher block.
// No dependencies; imported by the round lane, the keystream core and the top level.
package cc20_pkg;

  // ChaCha20 constant words ("expand 32-byte k")
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  // Round schedule: 20 rounds, alternating column and diagonal
  localparam int unsigned NUM_ROUNDS = 20;
  localparam int unsigned RND_W      = 5;
  localparam int unsigned NUM_LANES  = 4;

  // Keystream block geometry
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned BLOCK_BITS  = 512;

  // Stream payload layout
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned TDATA_W    = 72;
  localparam int unsigned ITEM_BYTES = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0     = 3'd0,
    CFG_KEY_1     = 3'd1,
    CFG_KEY_2     = 3'd2,
    CFG_KEY_3     = 3'd3,
    CFG_NONCE_LO  = 3'd4,
    CFG_NONCE_HI  = 3'd5,
    CFG_START_CTR = 3'd6
  } cfg_reg_e;

  typedef logic [BLOCK_WORDS-1:0][31:0] cc20_block_t;
  typedef logic [7:0][31:0]             cc20_key_t;
  typedef logic [2:0][31:0]             cc20_nonce_t;

  // Requests from the top level to the keystream core
  typedef struct packed {
    logic        start;
    logic        abort;
    logic [31:0] ctr;
  } cc20_gen_ctrl_t;

  // Status of the keystream core
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] ctr;
  } cc20_gen_stat_t;

endpackage

>>> hdl/cc20_qr_lane.sv
// One ChaCha20 quarter-round lane, purely combinational.
// Depends on cc20_pkg; four copies run side by side inside cc20_core.
module cc20_qr_lane import cc20_pkg::*; (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  logic [31:0] a1, b1, c1, d1;
  logic [31:0] a2, b2, c2, d2;

  // Add, xor, rotate chain of one quarter round
  always_comb begin
    a1 = a_i + b_i;
    d1 = rotl(d_i ^ a1, 16);
    c1 = c_i + d1;
    b1 = rotl(b_i ^ c1, 12);
    a2 = a1 + b1;
    d2 = rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = rotl(b1 ^ c2, 7);
  end

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;

endmodule

>>> hdl/cc20_core.sv
// ChaCha20 keystream core: four quarter-round lanes, one round per cycle,
// then the final feed-forward add. Depends on cc20_pkg and cc20_qr_lane.
module cc20_core import cc20_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cc20_gen_ctrl_t ctrl_i,
  input  cc20_key_t      key_i,
  input  cc20_nonce_t    nonce_i,
  output cc20_gen_stat_t stat_o,
  output cc20_block_t    block_o
);

  function automatic cc20_block_t cc20_init(input cc20_key_t key, input cc20_nonce_t nonce,
                                            input logic [31:0] ctr);
    cc20_block_t s;
    s[0] = SIGMA_0;
    s[1] = SIGMA_1;
    s[2] = SIGMA_2;
    s[3] = SIGMA_3;
    for (int k = 0; k < 8; k++) begin
      s[4'(4 + k)] = key[3'(k)];
    end
    s[12] = ctr;
    s[13] = nonce[0];
    s[14] = nonce[1];
    s[15] = nonce[2];
    return s;
  endfunction

  logic             busy_q, busy_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [31:0]      ctr_q, ctr_d;
  cc20_block_t      x_q, x_d;

  logic                       diag;
  logic [NUM_LANES-1:0][31:0] la, lb, lc, ld;
  logic [NUM_LANES-1:0][31:0] oa, ob, oc, od;
  cc20_block_t                x_rnd;
  cc20_block_t                init_blk;
  logic                       last_rnd;

  // Odd rounds work on diagonals, even rounds on columns
  assign diag = rnd_q[0];

  // Lanes with their operand selection
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam int unsigned CB = 4 + l;
    localparam int unsigned CC = 8 + l;
    localparam int unsigned CD = 12 + l;
    localparam int unsigned DB = 4 + ((l + 1) & 3);
    localparam int unsigned DC = 8 + ((l + 2) & 3);
    localparam int unsigned DD = 12 + ((l + 3) & 3);

    assign la[l] = x_q[l];
    assign lb[l] = diag ? x_q[DB] : x_q[CB];
    assign lc[l] = diag ? x_q[DC] : x_q[CC];
    assign ld[l] = diag ? x_q[DD] : x_q[CD];

    cc20_qr_lane u_lane (
      .a_i (la[l]),
      .b_i (lb[l]),
      .c_i (lc[l]),
      .d_i (ld[l]),
      .a_o (oa[l]),
      .b_o (ob[l]),
      .c_o (oc[l]),
      .d_o (od[l])
    );
  end

  // Merge the lane results back into the state words
  always_comb begin
    x_rnd = x_q;
    for (int l = 0; l < NUM_LANES; l++) begin
      x_rnd[4'(l)] = oa[2'(l)];
      if (diag) begin
        x_rnd[4'(4 + ((l + 1) & 3))]  = ob[2'(l)];
        x_rnd[4'(8 + ((l + 2) & 3))]  = oc[2'(l)];
        x_rnd[4'(12 + ((l + 3) & 3))] = od[2'(l)];
      end else begin
        x_rnd[4'(4 + l)]  = ob[2'(l)];
        x_rnd[4'(8 + l)]  = oc[2'(l)];
        x_rnd[4'(12 + l)] = od[2'(l)];
      end
    end
  end

  assign last_rnd = (rnd_q == RND_W'(NUM_ROUNDS));

  // Sequence: load initial state, run the rounds, then hand out the block; abort stops it
  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    ctr_d  = ctr_q;
    x_d    = x_q;
    if (ctrl_i.abort) begin
      busy_d = 1'b0;
    end else if (!busy_q) begin
      if (ctrl_i.start) begin
        busy_d = 1'b1;
        rnd_d  = '0;
        ctr_d  = ctrl_i.ctr;
        x_d    = cc20_init(key_i, nonce_i, ctrl_i.ctr);
      end
    end else if (!last_rnd) begin
      rnd_d = rnd_q + RND_W'(1);
      x_d   = x_rnd;
    end else begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q <= ctr_d;
    x_q   <= x_d;
  end

  // Feed-forward add of the initial state
  assign init_blk = cc20_init(key_i, nonce_i, ctr_q);

  always_comb begin
    for (int w = 0; w < BLOCK_WORDS; w++) begin
      block_o[4'(w)] = x_q[4'(w)] + init_blk[4'(w)];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && last_rnd && !ctrl_i.abort;
  assign stat_o.ctr  = ctr_q;

endmodule

>>> hdl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: configuration registers, keystream prefetch
// buffer, per-word XOR and output register. Depends on cc20_pkg and cc20_core.
//
// XORs a message, one word of BYTES_PER_ITEM keystream bytes at a time, with the
// ChaCha20 keystream (96-bit nonce, 32-bit block counter, 20 rounds). A word is
// taken whenever a keystream block is on hand, and the result is held in the output
// register from the next cycle on. While that register waits for the sink the input
// is held off, and a new word is taken in the same cycle the sink takes the waiting
// result. The keystream core runs one round per cycle on four quarter-round lanes.
// The core fetches the next block ahead while the current one is used, and starts
// it the cycle after the buffered block is taken, so words of the current block
// are taken while the next one is computed.
// The first block of a message is fetched for start_counter while the block is
// idle; a configuration write, or a message that ends before its block is used
// up, discards the fetched block and the next word waits for a new one. Only
// the last word may be partial; its unused output bytes read as zero.
module chacha20_stream_cipher import cc20_pkg::*; #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,  // [63:0] data_in, [67:64] byte_count
  input  logic                  s_axis_tlast,  // last_item
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,  // [63:0] data_out, [67:64] byte_count_out
  output logic                  m_axis_tlast   // last_out
);

  localparam int unsigned WORDS_PER_BLOCK = 64 / BYTES_PER_ITEM;
  localparam int unsigned WOFS_W          = $clog2(WORDS_PER_BLOCK);
  localparam int unsigned ROT_W           = BYTES_PER_ITEM * 8;
  localparam logic [WOFS_W-1:0] WOFS_LAST = WOFS_W'(WORDS_PER_BLOCK - 1);

  // Configuration registers
  logic [3:0][63:0] key_q;
  logic [63:0]      nonce_lo_q;
  logic [31:0]      nonce_hi_q;
  logic [31:0]      start_ctr_q;
  logic             cfg_we;

  // Message state and keystream buffers
  logic              in_msg_q, in_msg_d;
  logic [WOFS_W-1:0] wofs_q, wofs_d;
  logic [31:0]       blk_ctr_q, blk_ctr_d;
  logic              nxt_vld_q, nxt_vld_d;
  logic [31:0]       nxt_ctr_q;
  cc20_block_t       nxt_q;
  cc20_block_t       cur_q;

  // Output register
  logic              m_vld_q, m_vld_d;
  logic [DATA_W-1:0] m_data_q;
  logic [CNT_W-1:0]  m_cnt_q;
  logic              m_last_q;

  cc20_gen_ctrl_t gen_ctrl;
  cc20_gen_stat_t gen_stat;
  cc20_block_t    gen_block;
  cc20_nonce_t    nonce;

  logic                  need_new;
  logic [31:0]           want_ctr;
  logic                  nxt_match;
  logic                  nxt_drop;
  logic                  out_free;
  logic                  in_xfer;
  cc20_block_t           ks_sel;
  logic [BLOCK_BITS-1:0] ks_bits;
  logic [WOFS_W-1:0]     wofs_base;
  logic [DATA_W-1:0]     data_in;
  logic [CNT_W-1:0]      byte_count;
  logic [DATA_W-1:0]     data_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_ctr_q <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_KEY_0:     key_q[0]    <= cfg_data_i;
        CFG_KEY_1:     key_q[1]    <= cfg_data_i;
        CFG_KEY_2:     key_q[2]    <= cfg_data_i;
        CFG_KEY_3:     key_q[3]    <= cfg_data_i;
        CFG_NONCE_LO:  nonce_lo_q  <= cfg_data_i;
        CFG_NONCE_HI:  nonce_hi_q  <= cfg_data_i[31:0];
        CFG_START_CTR: start_ctr_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign nonce = {nonce_hi_q, nonce_lo_q};

  // Block the next word needs, and whether the buffered block is that one
  assign need_new  = !in_msg_q || (wofs_q == '0);
  assign want_ctr  = in_msg_q ? blk_ctr_q : start_ctr_q;
  assign nxt_match = nxt_vld_q && (nxt_ctr_q == want_ctr);
  assign nxt_drop  = nxt_vld_q && (nxt_ctr_q != want_ctr);

  // Prefetch: start when the buffer is empty, abort on a stale counter or a configuration write
  assign gen_ctrl.start = !gen_stat.busy && !nxt_vld_q;
  assign gen_ctrl.abort = cfg_we || (gen_stat.busy && (gen_stat.ctr != want_ctr));
  assign gen_ctrl.ctr   = want_ctr;

  cc20_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .key_i   (key_q),
    .nonce_i (nonce),
    .stat_o  (gen_stat),
    .block_o (gen_block)
  );

  // Input handshake
  assign out_free      = !m_vld_q || m_axis_tready;
  assign s_axis_tready = out_free && (!need_new || nxt_match);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign data_in    = s_axis_tdata[DATA_W-1:0];
  assign byte_count = s_axis_tdata[DATA_W +: CNT_W];

  // Keystream bytes for this word sit in the low bits of the selected block
  assign ks_sel  = need_new ? nxt_q : cur_q;
  assign ks_bits = ks_sel;

  // XOR and zero the bytes past the valid count
  always_comb begin
    for (int b = 0; b < ITEM_BYTES; b++) begin
      if ((b < BYTES_PER_ITEM) && (byte_count > CNT_W'(b))) begin
        data_out[8*b +: 8] = data_in[8*b +: 8] ^ ks_bits[8*b +: 8];
      end else begin
        data_out[8*b +: 8] = 8'h00;
      end
    end
  end

  // Message state update
  assign wofs_base = in_msg_q ? wofs_q : '0;

  always_comb begin
    in_msg_d  = in_msg_q;
    wofs_d    = wofs_q;
    blk_ctr_d = blk_ctr_q;
    if (in_xfer) begin
      in_msg_d = !s_axis_tlast;
      wofs_d   = (wofs_base == WOFS_LAST) ? '0 : wofs_base + WOFS_W'(1);
      if (need_new) begin
        blk_ctr_d = want_ctr + 32'd1;
      end
    end
  end

  // Prefetch buffer valid: drop on config write or stale tag, clear on use, set when a block is done
  always_comb begin
    nxt_vld_d = nxt_vld_q;
    if (cfg_we || nxt_drop || (in_xfer && need_new)) begin
      nxt_vld_d = 1'b0;
    end else if (gen_stat.done) begin
      nxt_vld_d = 1'b1;
    end
  end

  // Output register valid
  always_comb begin
    m_vld_d = m_vld_q;
    if (in_xfer) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q  <= 1'b0;
      wofs_q    <= '0;
      blk_ctr_q <= '0;
      nxt_vld_q <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      in_msg_q  <= in_msg_d;
      wofs_q    <= wofs_d;
      blk_ctr_q <= blk_ctr_d;
      nxt_vld_q <= nxt_vld_d;
      m_vld_q   <= m_vld_d;
    end
  end

  // Payload: capture fresh blocks, rotate the used bytes out, load the result
  always_ff @(posedge clk_i) begin
    if (gen_stat.done) begin
      nxt_q     <= gen_block;
      nxt_ctr_q <= gen_stat.ctr;
    end
    if (in_xfer) begin
      cur_q    <= {ks_bits[ROT_W-1:0], ks_bits[BLOCK_BITS-1:ROT_W]};
      m_data_q <= data_out;
      m_cnt_q  <= byte_count;
      m_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {{(TDATA_W - DATA_W - CNT_W){1'b0}}, m_cnt_q, m_data_q};
  assign m_axis_tlast  = m_last_q;

endmodule

>>> dv/chacha20_keystream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for chacha20_stream_cipher: follows configuration writes, predicts every
// output transfer from the input transfers and compares them. Depends on cc20_pkg.
module chacha20_keystream_checker import cc20_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [TDATA_W-1:0]    in_data_i,   // [63:0] data_in, [67:64] byte_count
  input  logic                  in_last_i,   // last_item
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [TDATA_W-1:0]    out_data_i,  // [63:0] data_out, [67:64] byte_count_out
  input  logic                  out_last_i,  // last_out
  output int                    err_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              last;
  } cipher_word_t;

  // Shadow copy of the configuration registers
  logic [63:0] cfg_key [4];
  logic [63:0] cfg_nonce_lo;
  logic [31:0] cfg_nonce_hi;
  logic [31:0] cfg_start_ctr;

  // Cipher state as the block should hold it
  cc20_block_t ks_words;
  logic [31:0] next_ctr;
  logic [2:0]  word_pos;
  logic        msg_open;

  cipher_word_t cipher_words_q[$];
  int           err_count;
  int           pending_cnt;
  int           out_idx;

  assign err_count_o = err_count;
  assign pending_o   = pending_cnt;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // ChaCha20 block function for the current key and nonce
  function automatic cc20_block_t keystream_block_for(logic [31:0] ctr);
    logic [31:0] init [16];
    logic [31:0] x [16];
    cc20_block_t blk;
    int a, b, c, d;
    init[0] = SIGMA_0;
    init[1] = SIGMA_1;
    init[2] = SIGMA_2;
    init[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = cfg_key[i][31:0];
      init[5 + 2*i] = cfg_key[i][63:32];
    end
    init[12] = ctr;
    init[13] = cfg_nonce_lo[31:0];
    init[14] = cfg_nonce_lo[63:32];
    init[15] = cfg_nonce_hi;
    x = init;
    // even rounds work on columns, odd rounds on diagonals
    for (int r = 0; r < 20; r++) begin
      for (int q = 0; q < 4; q++) begin
        a = q;
        if (r % 2 == 0) begin
          b = 4 + q;
          c = 8 + q;
          d = 12 + q;
        end else begin
          b = 4 + (q + 1) % 4;
          c = 8 + (q + 2) % 4;
          d = 12 + (q + 3) % 4;
        end
        x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) blk[i] = x[i] + init[i];
    return blk;
  endfunction

  // Work out the cipher word for one input transfer and queue it
  task automatic predict_word(logic [63:0] d, logic [3:0] n, logic l);
    logic [63:0]  ks64;
    logic [63:0]  mask;
    int           valid;
    cipher_word_t w;
    valid = (n > 4'd8) ? 8 : int'(n);
    if (!msg_open) begin
      next_ctr = cfg_start_ctr;
      word_pos = '0;
    end
    if (word_pos == 3'd0) begin
      ks_words = keystream_block_for(next_ctr);
      next_ctr = next_ctr + 32'd1;
    end
    ks64 = {ks_words[2*int'(word_pos) + 1], ks_words[2*int'(word_pos)]};
    mask = '0;
    for (int b = 0; b < valid; b++) mask[8*b +: 8] = 8'hFF;
    w.data  = (d ^ ks64) & mask;
    w.count = n;
    w.last  = l;
    cipher_words_q.push_back(w);
    word_pos = word_pos + 3'd1;
    msg_open = !l;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < 40)
      $display("%0t: output transfer %0d, %s: got %h, expected %h",
               $realtime, out_idx, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_word_t got;
    cipher_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cfg_key[i] = '0;
      cfg_nonce_lo  = '0;
      cfg_nonce_hi  = '0;
      cfg_start_ctr = '0;
      next_ctr      = '0;
      word_pos      = '0;
      msg_open      = 1'b0;
      cipher_words_q.delete();
      pending_cnt   = 0;
    end else begin
      // track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_KEY_0:     cfg_key[0]    = cfg_data_i;
          CFG_KEY_1:     cfg_key[1]    = cfg_data_i;
          CFG_KEY_2:     cfg_key[2]    = cfg_data_i;
          CFG_KEY_3:     cfg_key[3]    = cfg_data_i;
          CFG_NONCE_LO:  cfg_nonce_lo  = cfg_data_i;
          CFG_NONCE_HI:  cfg_nonce_hi  = cfg_data_i[31:0];
          CFG_START_CTR: cfg_start_ctr = cfg_data_i[31:0];
          default: ;
        endcase
      end
      // compare each output transfer with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got.data  = out_data_i[DATA_W-1:0];
        got.count = out_data_i[DATA_W +: CNT_W];
        got.last  = out_last_i;
        if (cipher_words_q.size() == 0) begin
          report("no transfer expected", got.data, '0);
        end else begin
          want = cipher_words_q.pop_front();
          if (got.data !== want.data) report("data_out", got.data, want.data);
          if (got.count !== want.count)
            report("byte_count_out", 64'(got.count), 64'(want.count));
          if (got.last !== want.last) report("last_out", 64'(got.last), 64'(want.last));
        end
        if (out_data_i[TDATA_W-1:DATA_W+CNT_W] !== '0)
          report("tdata padding", 64'(out_data_i[TDATA_W-1:DATA_W+CNT_W]), '0);
        out_idx++;
      end
      // predict from each input transfer
      if (in_valid_i && in_ready_i)
        predict_word(in_data_i[DATA_W-1:0], in_data_i[DATA_W +: CNT_W], in_last_i);
      pending_cnt = cipher_words_q.size();
    end
  end

endmodule

>>> dv/chacha20_stream_cipher_tb.sv
`timescale 1ns / 100ps
// Testbench top for chacha20_stream_cipher: clock, reset, configuration and stream
// stimulus with varied idling. Depends on cc20_pkg and chacha20_keystream_checker.
module chacha20_stream_cipher_tb;
  import cc20_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_STALL   = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 60;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // [63:0] data_in, [67:64] byte_count
  logic                  s_axis_tlast  = 1'b0;  // last_item
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;  // [63:0] data_out, [67:64] byte_count_out
  logic                  m_axis_tlast;  // last_out

  int   src_idle_pct   = 0;
  int   snk_stall_pct  = 0;
  logic long_stall_req = 1'b0;
  int   stall_left;
  int   fail_count;
  int   pending;
  int   cycle_cnt      = 0;

  always #5 clk_i = ~clk_i;

  chacha20_stream_cipher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  chacha20_keystream_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_last_i  (m_axis_tlast),
    .err_count_o (fail_count),
    .pending_o   (pending)
  );

  // Sink: random stalls, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (long_stall_req) begin
      m_axis_tready <= 1'b0;
      stall_left    <= LONG_STALL;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run if it hangs
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL chacha20_stream_cipher");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Leave valid high; the caller drops it after its last write
  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_config(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                             logic [63:0] k3, logic [63:0] nlo, logic [31:0] nhi,
                             logic [31:0] sc);
    write_reg(CFG_KEY_0, k0);
    write_reg(CFG_KEY_1, k1);
    write_reg(CFG_KEY_2, k2);
    write_reg(CFG_KEY_3, k3);
    write_reg(CFG_NONCE_LO, nlo);
    write_reg(CFG_NONCE_HI, {32'h0, nhi});
    write_reg(CFG_START_CTR, {32'h0, sc});
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one word after a random idle gap and hold it until taken
  task automatic send_word(logic [63:0] d, logic [3:0] n, logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, n, d};
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait for every predicted word to come out
  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  task automatic set_idling(int src_pct, int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // Mostly whole messages with random payload, some stray words with odd counts
  task automatic run_traffic(int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        for (int w = 0; w < len; w++) begin
          if (w == len - 1) send_word(rand64(), 4'($urandom_range(1, 8)), 1'b1);
          else send_word(rand64(), 4'd8, 1'b0);
        end
        sent += len;
      end else begin
        send_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(3) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(0, 0);

    // Published encryption-example key and nonce, counter one
    load_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                64'h1f1e1d1c1b1a1918, 64'h4a00000000000000, 32'h0, 32'h1);
    // data extremes, partial word mid-message, zero count, oversized counts
    send_word(64'h0, 4'd8, 1'b0);
    send_word('1, 4'd8, 1'b0);
    send_word(rand64(), 4'd3, 1'b0);
    send_word(rand64(), 4'd0, 1'b0);
    send_word(rand64(), 4'd15, 1'b0);
    send_word(rand64(), 4'd9, 1'b1);
    // a new message restarts from the start counter
    send_word(64'h5555555555555555, 4'd8, 1'b1);
    end_phase();

    // All-ones settings: the counter wraps across a block boundary
    load_config('1, '1, '1, '1, '1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    for (int w = 0; w < 9; w++) send_word(64'hAAAAAAAAAAAAAAAA, 4'd8, 1'(w == 8));
    end_phase();

    // Change key, nonce and start counter in the middle of a message
    for (int w = 0; w < 4; w++) send_word(rand64(), 4'd8, 1'b0);
    end_phase();
    write_reg(CFG_KEY_0, rand64());
    write_reg(CFG_NONCE_HI, rand64());
    write_reg(CFG_START_CTR, 64'h0);
    cfg_valid_i <= 1'b0;
    for (int w = 0; w < 6; w++) send_word(rand64(), 4'd8, 1'(w == 5));

    // Random phases with changing settings and idling
    for (int p = 0; p < PHASES; p++) begin
      end_phase();
      case (p)
        0: load_config('0, '0, '0, '0, '0, 32'h0, 32'h0);
        2: load_config('1, '1, '1, '1, '1, 32'hFFFFFFFF, 32'hFFFFFFFE);
        default: load_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
                             $urandom_range(1) ? $urandom
                                               : 32'hFFFFFFFF - $urandom_range(3));
      endcase
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(57, 0);
        2: set_idling(0, 57);
        default: set_idling(22, 22);
      endcase
      // hold the sink off while the source keeps pushing
      if (p == 0) begin
        long_stall_req <= 1'b1;
        @(posedge clk_i);
        long_stall_req <= 1'b0;
      end
      run_traffic(PHASE_ITEMS);
    end
    end_phase();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS chacha20_stream_cipher");
    end else begin
      $display("FAIL chacha20_stream_cipher");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/cc20_pkg.sv
hdl/cc20_qr_lane.sv
hdl/cc20_core.sv
hdl/chacha20_stream_cipher.sv
dv/chacha20_keystream_checker.sv
dv/chacha20_stream_cipher_tb.sv
